// ===== design/pfa_pkg.sv =====
// Package: shared constants, types and codes for the page frame allocator.
`default_nettype none
package pfa_pkg;
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ACCESS = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  localparam logic [2:0] ST_RESIDENT = 3'd0;
  localparam logic [2:0] ST_LOADED   = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_ABSENT   = 3'd3;
  localparam logic [2:0] ST_FREED    = 3'd4;

  localparam logic [1:0] AM_FIRST = 2'd0;
  localparam logic [1:0] AM_BEST  = 2'd1;
  localparam logic [1:0] AM_WORST = 2'd2;
  localparam logic [1:0] AM_NEXT  = 2'd3;

  localparam logic REG_ALLOC = 1'b0;
  localparam logic REG_REPL  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DECIDE, S_EVICT, S_PICK, S_PLACE, S_TOUCH, S_FREE, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // latch request
    logic find_step;  // scan one frame for a match
    logic pick_init;  // start a free-frame scan
    logic pick_step;  // scan one frame for a free slot
    logic evict;      // release victim frame
    logic place;      // install page into chosen frame
    logic touch;      // move frame to LRU tail
    logic do_free;    // release found frame
    logic rm_step;    // one compaction step of list removal
    logic rm_fifo;    // compaction also covers the FIFO list
    logic set_res;    // set result fields for the case at hand
    logic [2:0] res_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic find_done;
    logic found;
    logic pick_done;
    logic pick_ok;
    logic rm_done;
    logic [1:0] op;
    logic lru_mode;
    logic has_res;
  } stat_t;
endpackage
`default_nettype wire

// ===== design/page_frame_allocator_with_replacement.sv =====
// Top level: page frame allocator with FIFO / LRU replacement.
//
//  channel   dir  handshake        payload
//  s_axis    in   tvalid/tready    tdata[1:0] opcode, [17:2] page_number
//  m_axis    out  tvalid/tready    tdata[2:0] status, [6:3] frame, [22:7] writeback_page
//                                  tuser[0] writeback_valid
//  cfg       in   cfg_we           cfg_idx, cfg_data
//
// Each request runs a frame-by-frame search loop, then as needed a free-frame
// scan and list compaction, each looping in a sequencer state.
// Reset (rst, synchronous) empties every frame at once. One request at a
// time; the result beat holds until taken, then the next request is taken.
`default_nettype none
module page_frame_allocator_with_replacement #(
  parameter int FRAMES    = pfa_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = pfa_pkg::PAGE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // opcode, page_number
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // status, frame, writeback_page
  output logic             m_axis_tuser,   // writeback_valid
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [1:0]  cfg_data
);
  import pfa_pkg::*;
  cmd_t  cmd;
  stat_t st;
  logic  busy, in_fire, out_fire;
  logic [2:0] r_status;
  logic [3:0] r_frame;
  logic       r_wbv;
  logic [PAGE_BITS-1:0] r_wbp;

  // opcode 3 is swallowed without a result
  assign in_fire  = s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != OP_IGNORE;
  assign s_axis_tready = !busy;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  pfa_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .st, .cmd, .busy, .res_valid(m_axis_tvalid)
  );

  pfa_datapath #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_dp (
    .clk, .rst, .cmd, .st,
    .in_op(s_axis_tdata[1:0]), .in_page(s_axis_tdata[17:2]),
    .cfg_we, .cfg_idx, .cfg_data,
    .res_status(r_status), .res_frame(r_frame), .res_wbv(r_wbv), .res_wbp(r_wbp)
  );

  assign m_axis_tdata = {1'b0, 16'(r_wbp), r_frame, r_status};
  assign m_axis_tuser = r_wbv;
endmodule
`default_nettype wire

// ===== design/pfa_ctrl.sv =====
// Controller: sequences lookup, eviction, placement, list update and free.
`default_nettype none
module pfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic          out_fire,
  input  wire pfa_pkg::stat_t st,
  output pfa_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               res_valid
);
  import pfa_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    busy = (state != S_IDLE);
    res_valid = (state == S_OUT);
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.take = 1'b1;
        state_next = S_FIND;
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (st.find_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.pick_init = 1'b1;
        if (st.op == OP_FREE) begin
          if (st.found) state_next = S_FREE;
          else begin
            cmd.set_res = 1'b1;
            cmd.res_status = ST_ABSENT;
            state_next = S_OUT;
          end
        end else if (st.found) begin
          cmd.set_res = 1'b1;
          cmd.res_status = ST_RESIDENT;
          state_next = S_TOUCH;
        end else state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick_step = 1'b1;
        if (st.pick_done) begin
          if (st.pick_ok) begin
            cmd.set_res = 1'b1;
            cmd.res_status = ST_LOADED;
            state_next = S_PLACE;
          end else state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.rm_step = 1'b1;
        cmd.rm_fifo = 1'b1;
        if (st.rm_done) begin
          cmd.evict = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_status = ST_EVICTED;
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_next = S_TOUCH;
      end
      S_TOUCH: begin
        if (st.op == OP_ACCESS && st.lru_mode && st.has_res) begin
          cmd.rm_step = 1'b1;
          if (st.rm_done) begin
            cmd.touch = 1'b1;
            state_next = S_OUT;
          end
        end else state_next = S_OUT;
      end
      S_FREE: begin
        cmd.rm_step = 1'b1;
        cmd.rm_fifo = 1'b1;
        if (st.rm_done) begin
          cmd.do_free = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_status = ST_FREED;
          state_next = S_OUT;
        end
      end
      S_OUT: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/pfa_datapath.sv =====
// Datapath: frame table, order lists, scan counters and result registers.
`default_nettype none
module pfa_datapath #(
  parameter int FRAMES    = pfa_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = pfa_pkg::PAGE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pfa_pkg::cmd_t        cmd,
  output pfa_pkg::stat_t            st,
  input  wire logic [1:0]           in_op,
  input  wire logic [15:0]          in_page,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_idx,
  input  wire logic [1:0]           cfg_data,
  output logic [2:0]                res_status,
  output logic [3:0]                res_frame,
  output logic                      res_wbv,
  output logic [PAGE_BITS-1:0]      res_wbp
);
  import pfa_pkg::*;
  localparam int FW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [CW-1:0] FR_C = CW'(FRAMES);
  localparam logic [FW-1:0] LAST = FW'(FRAMES - 1);

  logic [1:0] alloc_mode;
  logic       repl_mode;
  logic [FRAMES-1:0] used;
  logic [PAGE_BITS-1:0] fpage [FRAMES];
  logic [FW-1:0] fifo [FRAMES];
  logic [FW-1:0] lru [FRAMES];
  logic [CW-1:0] count;
  logic [FW-1:0] nptr;

  logic [1:0] op;
  logic [PAGE_BITS-1:0] page;
  logic [CW-1:0] scan;      // frame scan index (find/pick)
  logic [FW-1:0] tgt;       // found / chosen frame
  logic          found;
  logic          pick_ok;
  logic [FW-1:0] best;
  logic [CW-1:0] best_len, run_len;
  logic [FW-1:0] run_start;
  // list removal: read index, write index per list
  logic [CW-1:0] rd, wr, wr_f;
  logic [FW-1:0] rm_f;

  logic [FW-1:0] si, pi;
  assign si = scan[FW-1:0];
  assign pi = FW'((CW+1)'(nptr) + (CW+1)'(scan) >= (CW+1)'(FRAMES) ?
              (CW+1)'(nptr) + (CW+1)'(scan) - (CW+1)'(FRAMES) :
              (CW+1)'(nptr) + (CW+1)'(scan));

  // head of the active order list, held before compaction moves it
  logic [FW-1:0] victim;
  assign rm_f = (!found && op != OP_FREE && !pick_ok) ? victim : tgt;

  assign st.find_done = (scan == FR_C) || found;
  assign st.found     = found;
  assign st.pick_done = (scan == FR_C) || (pick_ok && alloc_mode != AM_WORST);
  assign st.pick_ok   = pick_ok || (alloc_mode == AM_WORST && best_len != '0);
  assign st.rm_done   = (rd == count);
  assign st.op        = op;
  assign st.lru_mode  = repl_mode;
  assign st.has_res   = (count != '0);

  logic wf_end;
  always_comb wf_end = (scan == FR_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_mode <= AM_FIRST;
      repl_mode  <= 1'b0;
      used  <= '0;
      count <= '0;
      nptr  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_ALLOC: alloc_mode <= cfg_data;
          REG_REPL:  repl_mode  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.evict) begin
        used[victim] <= 1'b0;
        count <= count - 1'b1;
      end
      if (cmd.do_free) begin
        used[tgt] <= 1'b0;
        count <= count - 1'b1;
      end
      if (cmd.place) begin
        used[tgt] <= 1'b1;
        if (count < FR_C) begin
          fifo[count[FW-1:0]] <= tgt;
          lru[count[FW-1:0]]  <= tgt;
          count <= count + 1'b1;
        end
        if (alloc_mode == AM_NEXT) nptr <= (tgt == LAST) ? '0 : tgt + 1'b1;
      end
    end
    // removal compaction over both lists (touch: LRU only)
    if (cmd.rm_step && rd != count) begin
      rd <= rd + 1'b1;
      if (lru[rd[FW-1:0]] != rm_f) begin
        lru[wr[FW-1:0]] <= lru[rd[FW-1:0]];
        wr <= wr + 1'b1;
      end
      if (cmd.rm_fifo && fifo[rd[FW-1:0]] != rm_f) begin
        fifo[wr_f[FW-1:0]] <= fifo[rd[FW-1:0]];
        wr_f <= wr_f + 1'b1;
      end
    end
    if (cmd.touch) lru[FW'(count - 1'b1)] <= tgt;
    if (cmd.take) begin
      op <= in_op;
      page <= PAGE_BITS'(in_page);
      scan <= '0;
      found <= 1'b0;
      rd <= '0;
      wr <= '0;
      wr_f <= '0;
    end
    if (cmd.find_step && !found && scan != FR_C) begin
      if (used[si] && fpage[si] == page) begin
        found <= 1'b1;
        tgt <= si;
      end else scan <= scan + 1'b1;
    end
    if (cmd.pick_init) begin
      scan <= '0;
      pick_ok <= 1'b0;
      best_len <= '0;
      run_len <= '0;
      best <= '0;
      run_start <= '0;
      rd <= '0;
      wr <= '0;
      wr_f <= '0;
      victim <= repl_mode ? lru[0] : fifo[0];
    end
    if (cmd.pick_step && !wf_end) begin
      if (alloc_mode == AM_WORST) begin
        if (!used[si]) begin
          if (run_len == '0) run_start <= si;
          run_len <= run_len + 1'b1;
          if (run_len + 1'b1 > best_len) begin
            best_len <= run_len + 1'b1;
            best <= (run_len == '0) ? si : run_start;
          end
        end else run_len <= '0;
        scan <= scan + 1'b1;
      end else if (!pick_ok) begin
        if (!used[(alloc_mode == AM_NEXT) ? pi : si]) begin
          pick_ok <= 1'b1;
          tgt <= (alloc_mode == AM_NEXT) ? pi : si;
        end else scan <= scan + 1'b1;
      end
    end
    if (cmd.pick_step && wf_end && alloc_mode == AM_WORST && best_len != '0) begin
      tgt <= best;
      pick_ok <= 1'b1;
    end
    if (cmd.evict) tgt <= victim;
    if (cmd.place) fpage[tgt] <= page;
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      unique case (cmd.res_status)
        ST_ABSENT: begin
          res_frame <= '0;
          res_wbv <= 1'b0;
          res_wbp <= '0;
        end
        ST_EVICTED: begin
          res_frame <= 4'(victim);
          res_wbv <= 1'b1;
          res_wbp <= fpage[victim];
        end
        ST_FREED: begin
          res_frame <= 4'(tgt);
          res_wbv <= 1'b1;
          res_wbp <= fpage[tgt];
        end
        ST_LOADED: begin
          // worst fit settles its choice in this same cycle
          res_frame <= 4'((alloc_mode == AM_WORST) ? best : tgt);
          res_wbv <= 1'b0;
          res_wbp <= '0;
        end
        default: begin
          res_frame <= 4'(tgt);
          res_wbv <= 1'b0;
          res_wbp <= '0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/page_frame_allocator_with_replacement_tb.sv =====
// Testbench: page frame allocator, directed table then random requests checked by a predictor.
`timescale 1ns / 1ps
module page_frame_allocator_with_replacement_tb;
  import pfa_pkg::*;

  localparam int NFRAMES   = 16;
  // settle time before config writes
  localparam int SETTLE    = 3 * NFRAMES + 16;
  localparam int PHASE_LEN = 190;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        wb_valid;
    logic [15:0] wb_page;
  } result_t;

  // one directed request; typed = expected result given by hand
  typedef struct {
    logic [1:0]  op;
    logic [15:0] page;
    bit          typed;
    result_t     res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic [23:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [1:0]  cfg_data = '0;
  wire         s_ready;
  wire         m_valid;
  wire  [23:0] m_data;
  wire         m_user;

  page_frame_allocator_with_replacement u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data),   // [1:0] opcode, [17:2] page_number
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data),   // [2:0] status, [6:3] frame, [22:7] writeback_page
    .m_axis_tuser(m_user),   // [0] writeback_valid
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---- predictor state: own copy of the frame table and order lists ----
  logic        used_q [NFRAMES];
  logic [15:0] page_q [NFRAMES];
  logic [3:0]  fifo_q [NFRAMES];
  logic [3:0]  lru_q  [NFRAMES];
  int          resident;
  int          next_ptr;
  logic [1:0]  alloc_mode;
  logic        repl_mode;

  result_t     pending_results[$];
  bit          failed = 1'b0;
  int          idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both

  function automatic int lookup_frame(logic [15:0] page);
    for (int i = 0; i < NFRAMES; i++)
      if (used_q[i] && page_q[i] == page) return i;
    return NFRAMES;
  endfunction

  // compact one order list, dropping frame f from its first `resident` entries
  task automatic drop_frame(input bit lru_list, input int f);
    int k;
    k = 0;
    for (int i = 0; i < resident; i++) begin
      if (lru_list) begin
        if (lru_q[i] != f) begin lru_q[k] = lru_q[i]; k++; end
      end else begin
        if (fifo_q[i] != f) begin fifo_q[k] = fifo_q[i]; k++; end
      end
    end
  endtask

  task automatic pick_free_frame(output int f);
    int run_end, best_len, idx;
    f = NFRAMES;
    if (alloc_mode == AM_WORST) begin
      best_len = 0;
      for (int i = 0; i < NFRAMES; ) begin
        if (used_q[i]) begin
          i++;
        end else begin
          run_end = i;
          while (run_end < NFRAMES && !used_q[run_end]) run_end++;
          if (run_end - i > best_len) begin best_len = run_end - i; f = i; end
          i = run_end;
        end
      end
    end else if (alloc_mode == AM_NEXT) begin
      for (int k = 0; k < NFRAMES; k++) begin
        idx = (next_ptr + k) % NFRAMES;
        if (!used_q[idx]) begin
          next_ptr = (idx + 1) % NFRAMES;
          f = idx;
          break;
        end
      end
    end else begin
      for (int i = 0; i < NFRAMES; i++)
        if (!used_q[i]) begin f = i; break; end
    end
  endtask

  task automatic install_page(input logic [15:0] page, output int f, inout result_t r);
    int victim;
    pick_free_frame(f);
    r.status = ST_LOADED;
    if (f >= NFRAMES) begin
      victim = repl_mode ? lru_q[0] : fifo_q[0];
      drop_frame(1'b0, victim);
      drop_frame(1'b1, victim);
      if (resident > 0) resident--;
      used_q[victim] = 1'b0;
      r.status   = ST_EVICTED;
      r.wb_valid = 1'b1;
      r.wb_page  = page_q[victim];
      pick_free_frame(f);
      if (f >= NFRAMES) f = victim;
    end
    used_q[f] = 1'b1;
    page_q[f] = page;
    if (resident < NFRAMES) begin
      fifo_q[resident] = f;
      lru_q[resident]  = f;
      resident++;
    end
  endtask

  // advance the predictor by one request; has_res low for the ignored opcode
  task automatic predict_request(input logic [1:0] op, input logic [15:0] page,
                                 output bit has_res, output result_t r);
    int f;
    r = '0;
    has_res = (op != OP_IGNORE);
    if (!has_res) return;
    f = lookup_frame(page);
    if (op == OP_FREE) begin
      if (f >= NFRAMES) begin
        r.status = ST_ABSENT;
        f = 0;
      end else begin
        r.status   = ST_FREED;
        r.wb_valid = 1'b1;
        r.wb_page  = page_q[f];
        used_q[f]  = 1'b0;
        drop_frame(1'b0, f);
        drop_frame(1'b1, f);
        if (resident > 0) resident--;
      end
    end else begin
      if (f >= NFRAMES) install_page(page, f, r);
      else r.status = ST_RESIDENT;
      // access touches the LRU list only in LRU mode
      if (op == OP_ACCESS && repl_mode && resident > 0) begin
        drop_frame(1'b1, f);
        lru_q[resident-1] = f;
      end
    end
    r.frame = f[3:0];
  endtask

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // ---- receiver: random stalls, changed on the falling edge ----
  always @(negedge clk) begin
    if (rst) m_ready <= 1'b0;
    else case (idle_mode)
      2: m_ready <= !roll(51);
      3: m_ready <= !roll(29);
      default: m_ready <= 1'b1;
    endcase
  end

  // ---- result checker: compares each beat with the oldest expectation ----
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata=%h tuser=%b", m_data, m_user);
        failed = 1'b1;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_data[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_data[2:0]);
          failed = 1'b1;
        end
        if (m_data[6:3] !== want.frame) begin
          $error("frame: expected %0d, got %0d", want.frame, m_data[6:3]);
          failed = 1'b1;
        end
        if (m_user !== want.wb_valid) begin
          $error("writeback_valid: expected %0d, got %0d", want.wb_valid, m_user);
          failed = 1'b1;
        end
        if (m_data[22:7] !== want.wb_page) begin
          $error("writeback_page: expected %h, got %h", want.wb_page, m_data[22:7]);
          failed = 1'b1;
        end
      end
    end
  end

  // drive one request beat; called and returns on a falling edge
  task automatic send_request(input logic [1:0] op, input logic [15:0] page,
                              input bit typed, input result_t typed_res);
    bit      has_res;
    result_t r;
    while ((idle_mode == 1 && roll(51)) || (idle_mode == 3 && roll(29))) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {6'd0, page, op};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    predict_request(op, page, has_res, r);
    if (has_res) pending_results.insert(pending_results.size(), typed ? typed_res : r);
    @(negedge clk);
  endtask

  // wait until the block is idle, then write both registers
  task automatic set_modes(input logic [1:0] am, input logic rm);
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= REG_ALLOC; cfg_data <= am;
    @(negedge clk);
    cfg_idx <= REG_REPL; cfg_data <= {1'b0, rm};
    @(negedge clk);
    cfg_we <= 1'b0;
    alloc_mode = am;
    repl_mode  = rm;
  endtask

  function automatic result_t mk(logic [2:0] st, logic [3:0] fr, logic wv, logic [15:0] wp);
    result_t r;
    r.status = st; r.frame = fr; r.wb_valid = wv; r.wb_page = wp;
    return r;
  endfunction

  function automatic row_t mk_row(logic [1:0] op, logic [15:0] page, bit typed,
                                  result_t res);
    row_t w;
    w.op = op; w.page = page; w.typed = typed; w.res = res;
    return w;
  endfunction

  initial begin
    row_t        rows[$];
    row_t        row;
    logic [15:0] pool[20];
    logic [1:0]  op;
    logic [15:0] pg;
    int          pick;

    for (int i = 0; i < NFRAMES; i++) begin
      used_q[i] = 1'b0; page_q[i] = '0; fifo_q[i] = '0; lru_q[i] = '0;
    end
    resident = 0; next_ptr = 0; alloc_mode = AM_FIRST; repl_mode = 1'b0;

    // directed table, default modes: first fit, FIFO victim
    rows.insert(rows.size(), mk_row(OP_FREE, 16'h0000, 1, mk(ST_ABSENT, 0, 0, 16'h0000)));
    rows.insert(rows.size(), mk_row(OP_LOAD, 16'hFFFF, 1, mk(ST_LOADED, 0, 0, 16'h0000)));
    rows.insert(rows.size(), mk_row(OP_LOAD, 16'hFFFF, 1, mk(ST_RESIDENT, 0, 0, 16'h0000)));
    rows.insert(rows.size(), mk_row(OP_ACCESS, 16'h0000, 1, mk(ST_LOADED, 1, 0, 16'h0000)));
    for (int i = 1; i <= 14; i++)
      rows.insert(rows.size(), mk_row(OP_LOAD, 16'(i * 16'h1111 - 1), 0, '0));
    // table full: oldest frame 0 goes out
    rows.insert(rows.size(), mk_row(OP_LOAD, 16'h8000, 1, mk(ST_EVICTED, 0, 1, 16'hFFFF)));
    rows.insert(rows.size(), mk_row(OP_FREE, 16'h8000, 1, mk(ST_FREED, 0, 1, 16'h8000)));
    rows.insert(rows.size(), mk_row(OP_IGNORE, 16'h1234, 0, '0));  // ignored opcode
    rows.insert(rows.size(), mk_row(OP_FREE, 16'h5555, 1, mk(ST_ABSENT, 0, 0, 16'h0000)));
    rows.insert(rows.size(), mk_row(OP_ACCESS, 16'h5555, 0, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      send_request(row.op, row.page, row.typed, row.res);
    end

    // random phases: every mode pair, idling pattern rotating
    for (int ph = 0; ph < 8; ph++) begin
      set_modes(2'(ph % 4), 1'(ph / 4));
      idle_mode = ph % 4;
      pool[0] = 16'h0000;
      pool[1] = 16'hFFFF;
      for (int i = 2; i < 20; i++) pool[i] = 16'($urandom);
      for (int n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(99);
        if (pick < 35)      op = OP_LOAD;
        else if (pick < 75) op = OP_ACCESS;
        else if (pick < 95) op = OP_FREE;
        else                op = OP_IGNORE;
        pg = roll(90) ? pool[$urandom_range(19)] : 16'($urandom);
        send_request(op, pg, 0, '0);
      end
    end

    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("page_frame_allocator_with_replacement: match");
    end else begin
      $display("page_frame_allocator_with_replacement: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("page_frame_allocator_with_replacement: mismatch");
    $finish;
  end
endmodule

// ===== sim.f =====
design/pfa_pkg.sv
design/pfa_ctrl.sv
design/pfa_datapath.sv
design/page_frame_allocator_with_replacement.sv
tb/page_frame_allocator_with_replacement_tb.sv
